FILE: rtl/core/length_prefixed_frame_checker_top_assert.svh
// ----------------------------------------------------------------------------
// length prefixed frame checker assertion macros
// wraps concurrent assertions so that synthesis sees nothing
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_CHECKER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked on clk, masked while rst_n is low
`define LPFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on clk, also during reset
`define LPFC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPFC_ASSERT(name, prop, msg)
`define LPFC_ASSERT_RST(name, prop, msg)
`endif

`endif

FILE: rtl/core/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg
// shared types and constants of the length prefixed frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned HDR_IDX_W = 2;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CSUM_ERR = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } status_t;

  // length of 2^31 or more is flagged, i.e. the top bit is set
  function automatic status_t frame_status(input logic [LEN_W-1:0] len,
                                           input logic [BYTE_W-1:0] calc,
                                           input logic [BYTE_W-1:0] rcvd);
    status_t st;
    if (len[LEN_W-1]) begin
      st = STATUS_LEN_ERR;
    end else if (calc != rcvd) begin
      st = STATUS_CSUM_ERR;
    end else begin
      st = STATUS_OK;
    end
    return st;
  endfunction

endpackage

FILE: rtl/core/length_prefixed_frame_checker_top.sv
// the registered result is valid in the cycle after the frame's last byte transfers
// throughput: one byte per cycle if not stalled; per byte a 32-bit decrement and compare
// input stalls only when a frame-ending byte meets a full result register that is stalled
// reset: synchronous, active low; clears phase, header byte index and result valid
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_top
// checks a byte stream of frames: 4-byte big-endian length, checksum byte,
// payload; reports one status per frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_frame_checker_top_assert.svh"

module length_prefixed_frame_checker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input byte channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lpfc_pkg::BYTE_W-1:0]      in_data_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [lpfc_pkg::LEN_W-1:0]       out_payload_length,
  output logic [lpfc_pkg::BYTE_W-1:0]      out_computed_checksum,
  output logic [lpfc_pkg::BYTE_W-1:0]      out_received_checksum
);

  // frame parse phase; the unused code falls back to the length phase
  typedef enum logic [1:0] {
    PH_LENGTH   = 2'd0,
    PH_CHECKSUM = 2'd1,
    PH_PAYLOAD  = 2'd2,
    PH_SPARE    = 2'd3
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [lpfc_pkg::HDR_IDX_W-1:0]    hdr_idx_r, hdr_idx_nxt;
  logic [lpfc_pkg::LEN_W-1:0]        frame_len_r, frame_len_nxt;
  logic [lpfc_pkg::LEN_W-1:0]        remaining_r, remaining_nxt;
  logic [lpfc_pkg::BYTE_W-1:0]       hdr_csum_r, hdr_csum_nxt;
  logic [lpfc_pkg::BYTE_W-1:0]       run_xor_r, run_xor_nxt;

  logic                              out_valid_r, out_valid_nxt;
  lpfc_pkg::status_t                 out_status_r, out_status_nxt;
  logic [lpfc_pkg::LEN_W-1:0]        out_len_r, out_len_nxt;
  logic [lpfc_pkg::BYTE_W-1:0]       out_calc_r, out_calc_nxt;
  logic [lpfc_pkg::BYTE_W-1:0]       out_rcvd_r, out_rcvd_nxt;

  logic in_xfer;
  logic ends_frame;   // next byte closes the frame, known from state alone
  logic fin_xfer;

  // a frame ends on the checksum byte of an empty frame or the last payload byte
  assign ends_frame = ((phase_r == PH_CHECKSUM) && (frame_len_r == '0)) ||
                      ((phase_r == PH_PAYLOAD) &&
                       (remaining_r == lpfc_pkg::LEN_W'(1)));

  // bytes that end no frame pass even while a result waits
  assign in_stall = ends_frame && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign fin_xfer = in_xfer && ends_frame;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    frame_len_nxt  = frame_len_r;
    remaining_nxt  = remaining_r;
    hdr_csum_nxt   = hdr_csum_r;
    run_xor_nxt    = run_xor_r;

    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    out_calc_nxt   = out_calc_r;
    out_rcvd_nxt   = out_rcvd_r;
    // result register drains on its transfer, refills on a frame end
    out_valid_nxt  = (out_valid_r && out_stall) || fin_xfer;

    if (in_xfer) begin
      case (phase_r)
        PH_CHECKSUM: begin
          hdr_csum_nxt  = in_data_byte;
          run_xor_nxt   = '0;
          remaining_nxt = frame_len_r;
          if (frame_len_r == '0) begin
            // empty frame: result right after the checksum byte
            phase_nxt      = PH_LENGTH;
            hdr_idx_nxt    = '0;
            out_status_nxt = lpfc_pkg::frame_status(frame_len_r, '0, in_data_byte);
            out_len_nxt    = frame_len_r;
            out_calc_nxt   = '0;
            out_rcvd_nxt   = in_data_byte;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          run_xor_nxt   = run_xor_r ^ in_data_byte;
          remaining_nxt = remaining_r - lpfc_pkg::LEN_W'(1);
          if (ends_frame) begin
            phase_nxt      = PH_LENGTH;
            hdr_idx_nxt    = '0;
            remaining_nxt  = '0;
            out_status_nxt = lpfc_pkg::frame_status(frame_len_r,
                                                    run_xor_r ^ in_data_byte,
                                                    hdr_csum_r);
            out_len_nxt    = frame_len_r;
            out_calc_nxt   = run_xor_r ^ in_data_byte;
            out_rcvd_nxt   = hdr_csum_r;
          end
        end
        default: begin
          // length phase; the spare code restarts the header
          logic [lpfc_pkg::HDR_IDX_W-1:0] idx;
          idx = (phase_r == PH_LENGTH) ? hdr_idx_r : '0;
          // big-endian shift-in, fresh on the first length byte
          frame_len_nxt = {((idx == '0) ? 24'd0 : frame_len_r[23:0]), in_data_byte};
          hdr_idx_nxt   = idx + lpfc_pkg::HDR_IDX_W'(1);
          phase_nxt     = (idx == '1) ? PH_CHECKSUM : PH_LENGTH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // datapath registers need no reset
    frame_len_r  <= frame_len_nxt;
    remaining_r  <= remaining_nxt;
    hdr_csum_r   <= hdr_csum_nxt;
    run_xor_r    <= run_xor_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_calc_r   <= out_calc_nxt;
    out_rcvd_r   <= out_rcvd_nxt;
    if (!rst_n) begin
      phase_r     <= PH_LENGTH;
      hdr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_payload_length    = out_len_r;
  assign out_computed_checksum = out_calc_r;
  assign out_received_checksum = out_rcvd_r;

  // payload phase always has at least one byte due
  `LPFC_ASSERT(a_payload_nonzero, (phase_r == PH_PAYLOAD) |-> (remaining_r != '0),
               "payload phase with no bytes remaining")
  // header byte index only moves inside the length phase
  `LPFC_ASSERT(a_idx_in_length, (phase_r != PH_LENGTH) |-> (hdr_idx_r == '0),
               "header byte index set outside length phase")
  // a frame-ending transfer always produces a result next cycle
  `LPFC_ASSERT(a_frame_result, fin_xfer |=> (out_valid_r && (phase_r == PH_LENGTH)),
               "frame end without result")
  // status agrees with the reported length
  `LPFC_ASSERT(a_len_status, out_valid_r |->
               ((out_status_r == lpfc_pkg::STATUS_LEN_ERR) == out_len_r[lpfc_pkg::LEN_W-1]),
               "length error status mismatch")
  // reset leaves no stale result
  `LPFC_ASSERT_RST(a_reset_clears, !rst_n |=> (!out_valid_r && (phase_r == PH_LENGTH)),
                   "result or phase survived reset")

endmodule
